// ===== design/pecc_pkg.sv =====
`timescale 1ns / 1ps
package pecc_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_EXT_A_X = 2'd0;
	localparam logic [1:0] REG_EXT_A_Y = 2'd1;
	localparam logic [1:0] REG_EXT_B_X = 2'd2;
	localparam logic [1:0] REG_EXT_B_Y = 2'd3;

	localparam int EXT_BITS = 31;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_BOX     = 4'd1,
		OP_RD_A    = 4'd2,
		OP_RD_B    = 4'd3,
		OP_SEG     = 4'd4,
		OP_MUL     = 4'd5,
		OP_SUB     = 4'd6,
		OP_NEXT_X  = 4'd7
	} op_t;

	// Command bundle from controller to datapath.
	typedef struct packed {
		op_t        op;
		logic [1:0] cross_sel;
		logic       capture;
	} dp_cmd_t;

	// Status bundle from datapath to controller.
	typedef struct packed {
		logic box_hit;
		logic seg_overlap;
		logic straddle_hit;
	} dp_stat_t;

endpackage

// ===== design/pecc_ctrl.sv =====
`timescale 1ns / 1ps
module pecc_ctrl #(
	parameter int IDX_BITS = 8,
	parameter int CNT_BITS = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [CNT_BITS-1:0]      count_a,
	input  logic [CNT_BITS-1:0]      count_b,
	input  pecc_pkg::dp_stat_t       stat,
	input  logic                     res_free,
	output pecc_pkg::dp_cmd_t        cmd,
	output logic [IDX_BITS-1:0]      idx_a,
	output logic [IDX_BITS-1:0]      idx_b,
	output logic                     busy,
	output logic                     done,
	output logic                     hit
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_BOX   = 8'b0000_0010,
		ST_RDA   = 8'b0000_0100,
		ST_RDB   = 8'b0000_1000,
		ST_SEG   = 8'b0001_0000,
		ST_MUL   = 8'b0010_0000,
		ST_SUB   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [IDX_BITS-1:0] i_q, k_q;
	logic [1:0] cr_q;
	logic hit_q;
	logic last_i, last_k;

	// Segment i exists while i+1 < count.
	assign last_i = ((CNT_BITS+1)'(i_q) + (CNT_BITS+1)'(2)) >= (CNT_BITS+1)'(count_a);
	assign last_k = ((CNT_BITS+1)'(k_q) + (CNT_BITS+1)'(2)) >= (CNT_BITS+1)'(count_b);

	assign idx_a = i_q;
	assign idx_b = k_q;
	assign busy  = (state_q != ST_IDLE);
	assign done  = (state_q == ST_DONE) && res_free;
	assign hit   = hit_q;

	// Command decode per state.
	always_comb begin
		cmd = '{op: pecc_pkg::OP_NONE, cross_sel: cr_q, capture: 1'b0};
		unique case (state_q)
			ST_BOX: cmd.op = pecc_pkg::OP_BOX;
			ST_RDA: cmd.op = pecc_pkg::OP_RD_A;
			ST_RDB: cmd.op = pecc_pkg::OP_RD_B;
			ST_SEG: cmd.op = pecc_pkg::OP_SEG;
			ST_MUL: cmd.op = pecc_pkg::OP_MUL;
			ST_SUB: cmd.op = pecc_pkg::OP_SUB;
			default: cmd.op = pecc_pkg::OP_NONE;
		endcase
	end

	// Pair walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			k_q <= '0;
			cr_q <= '0;
			hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_BOX;
						i_q <= '0;
						k_q <= '0;
						hit_q <= 1'b0;
					end
				end
				ST_BOX: begin
					if (!stat.box_hit || count_a < CNT_BITS'(2) || count_b < CNT_BITS'(2))
						state_q <= ST_DONE;
					else
						state_q <= ST_RDA;
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_SEG;
				ST_SEG: begin
					cr_q <= '0;
					if (stat.seg_overlap)
						state_q <= ST_MUL;
					else if (last_k && last_i)
						state_q <= ST_DONE;
					else begin
						if (last_k) begin
							k_q <= '0;
							i_q <= i_q + IDX_BITS'(1);
						end else
							k_q <= k_q + IDX_BITS'(1);
						state_q <= ST_RDA;
					end
				end
				ST_MUL: state_q <= ST_SUB;
				ST_SUB: begin
					if (cr_q != 2'd3) begin
						cr_q <= cr_q + 2'd1;
						state_q <= ST_MUL;
					end else if (stat.straddle_hit) begin
						hit_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (last_k && last_i)
						state_q <= ST_DONE;
					else begin
						if (last_k) begin
							k_q <= '0;
							i_q <= i_q + IDX_BITS'(1);
						end else
							k_q <= k_q + IDX_BITS'(1);
						state_q <= ST_RDA;
					end
				end
				ST_DONE: if (res_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/pecc_dp.sv =====
`timescale 1ns / 1ps
module pecc_dp #(
	parameter int COORD_BITS = 32,
	parameter int IDX_BITS = 8,
	parameter int DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         wr_a,
	input  logic                         wr_b,
	input  logic [IDX_BITS-1:0]          wr_idx,
	input  logic signed [COORD_BITS-1:0] wx,
	input  logic signed [COORD_BITS-1:0] wy,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] oax,
	input  logic signed [COORD_BITS-1:0] oay,
	input  logic signed [COORD_BITS-1:0] obx,
	input  logic signed [COORD_BITS-1:0] oby,
	input  logic [pecc_pkg::EXT_BITS-1:0] eax,
	input  logic [pecc_pkg::EXT_BITS-1:0] eay,
	input  logic [pecc_pkg::EXT_BITS-1:0] ebx,
	input  logic [pecc_pkg::EXT_BITS-1:0] eby,
	input  pecc_pkg::dp_cmd_t            cmd,
	input  logic [IDX_BITS-1:0]          idx_a,
	input  logic [IDX_BITS-1:0]          idx_b,
	output pecc_pkg::dp_stat_t           stat
);

	localparam int PW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 2;
	localparam int MW = 2 * EW;
	localparam int BW = (COORD_BITS > pecc_pkg::EXT_BITS ? COORD_BITS : pecc_pkg::EXT_BITS) + 1;

	typedef logic signed [PW-1:0] pc_t;

	logic [2*COORD_BITS-1:0] mem_a [DEPTH];
	logic [2*COORD_BITS-1:0] mem_b [DEPTH];
	logic [2*COORD_BITS-1:0] ra0_q, ra1_q, rb0_q, rb1_q;
	logic signed [COORD_BITS-1:0] oax_q, oay_q, obx_q, oby_q;
	pc_t c1x, c1y, c2x, c2y, p1x, p1y, p2x, p2y;
	logic signed [EW-1:0] m1a, m1b, m2a, m2b;
	logic signed [MW-1:0] pr1_q, pr2_q;
	logic [1:0] sg_q [4];
	logic signed [MW-1:0] diff;
	logic signed [BW-1:0] box_oax, box_oay, box_obx, box_oby;
	logic signed [BW-1:0] box_eax, box_eay, box_ebx, box_eby;

	// Vertex stores; the second entry of a segment is read in the cycle after the first.
	always_ff @(posedge clk) begin
		if (wr_a) mem_a[wr_idx] <= {wx, wy};
		if (wr_b) mem_b[wr_idx] <= {wx, wy};
		if (cmd.op == pecc_pkg::OP_RD_A) begin
			ra0_q <= mem_a[idx_a];
			rb0_q <= mem_b[idx_b];
		end
		if (cmd.op == pecc_pkg::OP_RD_B) begin
			ra1_q <= mem_a[idx_a + IDX_BITS'(1)];
			rb1_q <= mem_b[idx_b + IDX_BITS'(1)];
		end
	end

	// Offsets are held for the whole check.
	always_ff @(posedge clk) begin
		if (start) begin
			oax_q <= oax;
			oay_q <= oay;
			obx_q <= obx;
			oby_q <= oby;
		end
	end

	function automatic pc_t place(input logic [COORD_BITS-1:0] v,
		input logic signed [COORD_BITS-1:0] o);
		pc_t r;
		r = PW'(signed'(v)) + PW'(o);
		return r;
	endfunction

	assign c1x = place(ra0_q[2*COORD_BITS-1:COORD_BITS], oax_q);
	assign c1y = place(ra0_q[COORD_BITS-1:0], oay_q);
	assign c2x = place(ra1_q[2*COORD_BITS-1:COORD_BITS], oax_q);
	assign c2y = place(ra1_q[COORD_BITS-1:0], oay_q);
	assign p1x = place(rb0_q[2*COORD_BITS-1:COORD_BITS], obx_q);
	assign p1y = place(rb0_q[COORD_BITS-1:0], oby_q);
	assign p2x = place(rb1_q[2*COORD_BITS-1:COORD_BITS], obx_q);
	assign p2y = place(rb1_q[COORD_BITS-1:0], oby_q);

	// Operand selection for the four cross products.
	// 0: (p1,p2,c1) 1: (p1,p2,c2) 2: (c1,c2,p1) 3: (c1,c2,p2)
	always_comb begin
		pc_t ox, oy, ax, ay, bx, by;
		case (cmd.cross_sel)
			2'd0: begin ox = p1x; oy = p1y; ax = p2x; ay = p2y; bx = c1x; by = c1y; end
			2'd1: begin ox = p1x; oy = p1y; ax = p2x; ay = p2y; bx = c2x; by = c2y; end
			2'd2: begin ox = c1x; oy = c1y; ax = c2x; ay = c2y; bx = p1x; by = p1y; end
			default: begin
				ox = c1x; oy = c1y; ax = c2x; ay = c2y; bx = p2x; by = p2y;
			end
		endcase
		m1a = EW'(ax) - EW'(ox);
		m1b = EW'(by) - EW'(oy);
		m2a = EW'(bx) - EW'(ox);
		m2b = EW'(ay) - EW'(oy);
	end

	assign diff = pr1_q - pr2_q;

	// Products and sign capture.
	always_ff @(posedge clk) begin
		if (cmd.op == pecc_pkg::OP_MUL) begin
			pr1_q <= MW'(m1a) * MW'(m1b);
			pr2_q <= MW'(m2a) * MW'(m2b);
		end
		if (cmd.op == pecc_pkg::OP_SUB)
			sg_q[cmd.cross_sel] <= {diff[MW-1], diff != '0};
	end

	// Placed box operands, all signed at one width so that the compares are signed.
	assign box_oax = BW'(oax_q);
	assign box_oay = BW'(oay_q);
	assign box_obx = BW'(obx_q);
	assign box_oby = BW'(oby_q);
	assign box_eax = signed'(BW'({1'b0, eax}));
	assign box_eay = signed'(BW'({1'b0, eay}));
	assign box_ebx = signed'(BW'({1'b0, ebx}));
	assign box_eby = signed'(BW'({1'b0, eby}));

	// Segment box overlap, evaluated straight from the read registers.
	logic seg_ov;
	always_comb begin
		pc_t xl1, xr1, yb1, yt1, xl2, xr2, yb2, yt2;
		xl1 = (c1x < c2x) ? c1x : c2x; xr1 = (c1x > c2x) ? c1x : c2x;
		yb1 = (c1y < c2y) ? c1y : c2y; yt1 = (c1y > c2y) ? c1y : c2y;
		xl2 = (p1x < p2x) ? p1x : p2x; xr2 = (p1x > p2x) ? p1x : p2x;
		yb2 = (p1y < p2y) ? p1y : p2y; yt2 = (p1y > p2y) ? p1y : p2y;
		seg_ov = !(xl1 > xr2 || xr1 < xl2 || yb1 > yt2 || yt1 < yb2);
	end

	// Straddle verdict; the last sign is taken straight from the subtractor.
	logic [1:0] s3;
	logic pos0, neg0, pos1, neg1, pos2, neg2, pos3, neg3;
	assign s3 = {diff[MW-1], diff != '0};
	assign pos0 = !sg_q[0][1] && sg_q[0][0];
	assign neg0 = sg_q[0][1];
	assign pos1 = !sg_q[1][1] && sg_q[1][0];
	assign neg1 = sg_q[1][1];
	assign pos2 = !sg_q[2][1] && sg_q[2][0];
	assign neg2 = sg_q[2][1];
	assign pos3 = !s3[1] && s3[0];
	assign neg3 = s3[1];

	assign stat.box_hit = !((box_oax >= box_obx + box_ebx)
		|| (box_oax + box_eax <= box_obx)
		|| (box_oay >= box_oby + box_eby)
		|| (box_oay + box_eay <= box_oby));
	assign stat.seg_overlap = seg_ov;
	assign stat.straddle_hit = !((pos0 && pos1) || (neg0 && neg1))
		&& !((pos2 && pos3) || (neg2 && neg3));

endmodule

// ===== design/polygon_edge_crossing_check.sv =====
`timescale 1ns / 1ps
// Polyline edge crossing check.
// Input channel (in_valid/in_ready) carries one item per transfer: command 0
// or 1 stores a vertex into list A or B, command 2 runs a check with the four
// placement offsets. A load gives no result; loads may follow each other on
// every cycle while no check runs and no result waits.
// A check raises out_valid without a segment walk when the placed boxes
// do not overlap or a list holds fewer than two vertices. Otherwise each
// segment pair is read and box-tested, and when its boxes overlap it
// reaches the cross-product test, in which the single shared pair of
// multipliers forms the four cross products in turn. The walk stops at
// the first hit. Input is held off during a check.
// The result (collide, truncated) sits in an output register on the
// out_valid/out_ready channel; if the receiver stalls, the block waits
// with its result and accepts no further item until the transfer.
// Reset clears the vertex counts, the overflow flag and the extents; vertex
// storage is not cleared. Extents are to be written by the user through
// cfg_we/cfg_index/cfg_data while the block is idle; this is not enforced.
module polygon_edge_crossing_check #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [30:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         first_point,
	input  logic signed [COORD_BITS-1:0] offset_a_x,
	input  logic signed [COORD_BITS-1:0] offset_a_y,
	input  logic signed [COORD_BITS-1:0] offset_b_x,
	input  logic signed [COORD_BITS-1:0] offset_b_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         collide,
	output logic                         truncated
);

	localparam int IDX_BITS = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

	logic [30:0] eax_q, eay_q, ebx_q, eby_q;
	logic [CNT_BITS-1:0] cnt_a_q, cnt_b_q, cur_cnt;
	logic ovf_q;
	logic acc, is_a, is_b, start, busy, done, hit;
	logic wr_a, wr_b, full;
	pecc_pkg::dp_cmd_t  cmd;
	pecc_pkg::dp_stat_t stat;
	logic [IDX_BITS-1:0] idx_a, idx_b;

	assign in_ready = !busy && !out_valid;
	assign acc   = in_valid && in_ready;
	assign is_a  = acc && (command == pecc_pkg::CMD_LOAD_A);
	assign is_b  = acc && (command == pecc_pkg::CMD_LOAD_B);
	assign start = acc && (command == pecc_pkg::CMD_CHECK);
	assign cur_cnt = first_point ? '0 : (is_a ? cnt_a_q : cnt_b_q);
	assign full  = cur_cnt >= CNT_BITS'(MAX_VERTICES);
	assign wr_a  = is_a && !full;
	assign wr_b  = is_b && !full;

	// Extent registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eax_q <= '0; eay_q <= '0; ebx_q <= '0; eby_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pecc_pkg::REG_EXT_A_X: eax_q <= cfg_data;
				pecc_pkg::REG_EXT_A_Y: eay_q <= cfg_data;
				pecc_pkg::REG_EXT_B_X: ebx_q <= cfg_data;
				pecc_pkg::REG_EXT_B_Y: eby_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Vertex counts and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0; cnt_b_q <= '0; ovf_q <= 1'b0;
		end else if (is_a || is_b) begin
			if (first_point) ovf_q <= 1'b0;
			if (full) ovf_q <= 1'b1;
			else if (is_a) cnt_a_q <= cur_cnt + CNT_BITS'(1);
			else cnt_b_q <= cur_cnt + CNT_BITS'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			collide <= hit;
			truncated <= ovf_q;
		end
	end

	pecc_ctrl #(.IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.count_a(cnt_a_q), .count_b(cnt_b_q), .stat(stat),
		.res_free(!out_valid), .cmd(cmd), .idx_a(idx_a), .idx_b(idx_b),
		.busy(busy), .done(done), .hit(hit)
	);

	pecc_dp #(.COORD_BITS(COORD_BITS), .IDX_BITS(IDX_BITS), .DEPTH(MAX_VERTICES)) u_dp (
		.clk(clk), .wr_a(wr_a), .wr_b(wr_b), .wr_idx(cur_cnt[IDX_BITS-1:0]),
		.wx(point_x), .wy(point_y), .start(start),
		.oax(offset_a_x), .oay(offset_a_y), .obx(offset_b_x), .oby(offset_b_y),
		.eax(eax_q), .eay(eay_q), .ebx(ebx_q), .eby(eby_q),
		.cmd(cmd), .idx_a(idx_a), .idx_b(idx_b), .stat(stat)
	);

endmodule

// ===== tb/polygon_edge_crossing_check_test.sv =====
`timescale 1ns / 1ps
module polygon_edge_crossing_check_test;

	localparam int MAX_VERTICES = 256;
	localparam int COORD_BITS = 32;

	typedef logic signed [79:0] wide_t;

	typedef struct {
		logic [1:0]                   cmd;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic                         first;
		logic signed [COORD_BITS-1:0] oax;
		logic signed [COORD_BITS-1:0] oay;
		logic signed [COORD_BITS-1:0] obx;
		logic signed [COORD_BITS-1:0] oby;
	} vertex_item_t;

	typedef struct {
		logic collide;
		logic truncated;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] command;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic first_point;
	logic signed [COORD_BITS-1:0] offset_a_x;
	logic signed [COORD_BITS-1:0] offset_a_y;
	logic signed [COORD_BITS-1:0] offset_b_x;
	logic signed [COORD_BITS-1:0] offset_b_y;
	logic out_valid;
	logic out_ready;
	logic collide;
	logic truncated;

	// Shadow copy of the block state used for prediction.
	logic signed [COORD_BITS-1:0] poly_a_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_a_y [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_b_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_b_y [MAX_VERTICES];
	int unsigned n_verts_a;
	int unsigned n_verts_b;
	logic lost_vertex;
	logic [30:0] ext_a_x, ext_a_y, ext_b_x, ext_b_y;

	verdict_t pending_verdicts[$];
	int mismatches;
	int items_sent;
	bit no_idle;
	bit hold_req;

	polygon_edge_crossing_check #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.point_x(point_x),
		.point_y(point_y),
		.first_point(first_point),
		.offset_a_x(offset_a_x),
		.offset_a_y(offset_a_y),
		.offset_b_x(offset_b_x),
		.offset_b_y(offset_b_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.collide(collide),
		.truncated(truncated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic wide_t wmin(wide_t a, wide_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic wide_t wmax(wide_t a, wide_t b);
		return (a > b) ? a : b;
	endfunction

	// Sign of (a - o) x (b - o), formed exactly at 80 bits.
	function automatic int turn_sign(wide_t ox, wide_t oy, wide_t ax, wide_t ay,
			wide_t bx, wide_t by);
		wide_t d;
		d = (ax - ox) * (by - oy) - (bx - ox) * (ay - oy);
		if (d < 0) return -1;
		return (d == 0) ? 0 : 1;
	endfunction

	// True unless c and d lie strictly on the same side of line p-q.
	function automatic bit spans_line(wide_t px, wide_t py, wide_t qx, wide_t qy,
			wide_t cx, wide_t cy, wide_t dx, wide_t dy);
		int s1;
		int s2;
		s1 = turn_sign(px, py, qx, qy, cx, cy);
		s2 = turn_sign(px, py, qx, qy, dx, dy);
		return !((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0));
	endfunction

	// Expected collide flag for a check with the given placement offsets.
	function automatic logic predict_collision(vertex_item_t it);
		longint ax;
		longint ay;
		longint bx;
		longint by;
		wide_t c1x, c1y, c2x, c2y, p1x, p1y, p2x, p2y;
		ax = it.oax;
		ay = it.oay;
		bx = it.obx;
		by = it.oby;
		if (ax >= bx + longint'(ext_b_x) || ax + longint'(ext_a_x) <= bx ||
				ay >= by + longint'(ext_b_y) || ay + longint'(ext_a_y) <= by)
			return 1'b0;
		for (int i = 0; i + 1 < n_verts_a; i++) begin
			c1x = poly_a_x[i];     c1x = c1x + it.oax;
			c1y = poly_a_y[i];     c1y = c1y + it.oay;
			c2x = poly_a_x[i + 1]; c2x = c2x + it.oax;
			c2y = poly_a_y[i + 1]; c2y = c2y + it.oay;
			for (int k = 0; k + 1 < n_verts_b; k++) begin
				p1x = poly_b_x[k];     p1x = p1x + it.obx;
				p1y = poly_b_y[k];     p1y = p1y + it.oby;
				p2x = poly_b_x[k + 1]; p2x = p2x + it.obx;
				p2y = poly_b_y[k + 1]; p2y = p2y + it.oby;
				if (wmin(c1x, c2x) > wmax(p1x, p2x) || wmax(c1x, c2x) < wmin(p1x, p2x) ||
						wmin(c1y, c2y) > wmax(p1y, p2y) || wmax(c1y, c2y) < wmin(p1y, p2y))
					continue;
				if (spans_line(p1x, p1y, p2x, p2y, c1x, c1y, c2x, c2y) &&
						spans_line(c1x, c1y, c2x, c2y, p1x, p1y, p2x, p2y))
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Update the shadow state for an accepted transfer.
	task automatic apply_item(vertex_item_t it);
		verdict_t v;
		case (it.cmd)
			pecc_pkg::CMD_LOAD_A: begin
				if (it.first) begin
					n_verts_a = 0;
					lost_vertex = 1'b0;
				end
				if (n_verts_a >= MAX_VERTICES) begin
					lost_vertex = 1'b1;
				end else begin
					poly_a_x[n_verts_a] = it.px;
					poly_a_y[n_verts_a] = it.py;
					n_verts_a++;
				end
			end
			pecc_pkg::CMD_LOAD_B: begin
				if (it.first) begin
					n_verts_b = 0;
					lost_vertex = 1'b0;
				end
				if (n_verts_b >= MAX_VERTICES) begin
					lost_vertex = 1'b1;
				end else begin
					poly_b_x[n_verts_b] = it.px;
					poly_b_y[n_verts_b] = it.py;
					n_verts_b++;
				end
			end
			pecc_pkg::CMD_CHECK: begin
				v.collide = predict_collision(it);
				v.truncated = lost_vertex;
				pending_verdicts.push_back(v);
			end
			default: begin
			end
		endcase
	endtask

	// Offer one item, then wait for its transfer.
	task automatic send_item(vertex_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.cmd;
		point_x <= it.px;
		point_y <= it.py;
		first_point <= it.first;
		offset_a_x <= it.oax;
		offset_a_y <= it.oay;
		offset_b_x <= it.obx;
		offset_b_y <= it.oby;
		do @(posedge clk); while (!in_ready);
		apply_item(it);
		items_sent++;
	endtask

	// Coordinate: mostly a small range so that segments meet, sometimes any value.
	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $signed($urandom_range(0, 64)) - 32;
	endfunction

	function automatic vertex_item_t rand_item(logic [1:0] cmd);
		vertex_item_t it;
		it.cmd = cmd;
		it.px = rand_coord();
		it.py = rand_coord();
		it.first = 1'($urandom_range(0, 1));
		it.oax = rand_coord();
		it.oay = rand_coord();
		it.obx = rand_coord();
		it.oby = rand_coord();
		return it;
	endfunction

	task automatic put_vertex(logic [1:0] cmd, logic first, int x, int y);
		vertex_item_t it;
		it = rand_item(cmd);
		it.first = first;
		it.px = x;
		it.py = y;
		send_item(it);
	endtask

	task automatic run_check(int oax, int oay, int obx, int oby);
		vertex_item_t it;
		it = rand_item(pecc_pkg::CMD_CHECK);
		it.oax = oax;
		it.oay = oay;
		it.obx = obx;
		it.oby = oby;
		send_item(it);
	endtask

	// Stop offering and wait until every result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Write all four extents; only called when no result is pending.
	task automatic set_extents(logic [30:0] eax, logic [30:0] eay, logic [30:0] ebx,
			logic [30:0] eby);
		cfg_we <= 1'b1;
		cfg_index <= pecc_pkg::REG_EXT_A_X; cfg_data <= eax; @(posedge clk);
		cfg_index <= pecc_pkg::REG_EXT_A_Y; cfg_data <= eay; @(posedge clk);
		cfg_index <= pecc_pkg::REG_EXT_B_X; cfg_data <= ebx; @(posedge clk);
		cfg_index <= pecc_pkg::REG_EXT_B_Y; cfg_data <= eby; @(posedge clk);
		cfg_we <= 1'b0;
		ext_a_x = eax;
		ext_a_y = eay;
		ext_b_x = ebx;
		ext_b_y = eby;
	endtask

	// Result side: random stalls, one long hold on request, and comparison.
	initial begin
		int stall;
		verdict_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = 400;
				hold_req = 1'b0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result collide=%0b truncated=%0b", collide, truncated);
			end else begin
				want = pending_verdicts.pop_front();
				if (collide !== want.collide || truncated !== want.truncated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected collide=%0b truncated=%0b, got %0b %0b",
							want.collide, want.truncated, collide, truncated);
				end
			end
		end
	end

	// Crossing, touching, collinear, parallel, separated boxes, short list, extremes.
	task automatic test_directed();
		vertex_item_t it;
		set_extents(31'd100, 31'd100, 31'd100, 31'd100);
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b1, 0, 0);
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b0, 10, 10);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b1, 0, 10);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b0, 10, 0);
		run_check(0, 0, 0, 0);
		// Segments that only share an endpoint.
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b1, 10, 10);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b0, 20, 0);
		run_check(0, 0, 0, 0);
		// Collinear overlap, then parallel lines with no contact.
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b1, 0, 0);
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b0, 10, 0);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b1, 5, 0);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b0, 15, 0);
		run_check(0, 0, 0, 0);
		run_check(0, 0, 0, 5);
		// Placed boxes apart.
		run_check(0, 0, 500, 0);
		// Unused command changes nothing.
		it = rand_item(pecc_pkg::CMD_LOAD_A);
		it.cmd = pecc_pkg::CMD_UNUSED;
		send_item(it);
		// List A with one vertex has no segments.
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b1, 3, 3);
		run_check(0, 0, 0, 0);
		drain();
		set_extents(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b1, 32'sh7fffffff, 32'sh80000000);
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b0, 32'sh80000000, 32'sh7fffffff);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b1, 32'sh80000000, 32'sh80000000);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b0, 32'sh7fffffff, 32'sh7fffffff);
		run_check(0, 0, 0, 0);
		run_check(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
		run_check(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		drain();
		set_extents(31'd0, 31'd0, 31'd0, 31'd0);
		run_check(0, 0, 0, 0);
		drain();
	endtask

	// Fill list A past capacity, then clear the flag by a restart.
	task automatic test_overflow();
		set_extents(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		no_idle = 1'b1;
		for (int i = 0; i < MAX_VERTICES + 3; i++)
			put_vertex(pecc_pkg::CMD_LOAD_A, i == 0, rand_coord(), rand_coord());
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b1, rand_coord(), rand_coord());
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b0, rand_coord(), rand_coord());
		no_idle = 1'b0;
		run_check(0, 0, 0, 0);
		run_check(1000, 1000, -1000, -1000);
		put_vertex(pecc_pkg::CMD_LOAD_B, 1'b1, 1, 1);
		run_check(0, 0, 0, 0);
		put_vertex(pecc_pkg::CMD_LOAD_A, 1'b1, 0, 0);
		drain();
	endtask

	// Result side holds off while checks keep coming, so the input stalls.
	task automatic test_backpressure();
		set_extents(31'd80, 31'd80, 31'd80, 31'd80);
		hold_req = 1'b1;
		for (int n = 0; n < 6; n++) begin
			put_vertex(pecc_pkg::CMD_LOAD_A, n == 0, rand_coord(), rand_coord());
			put_vertex(pecc_pkg::CMD_LOAD_B, n == 0, rand_coord(), rand_coord());
			send_item(rand_item(pecc_pkg::CMD_CHECK));
		end
		drain();
	endtask

	// Well-formed polyline pairs with random content, plus some noise.
	task automatic test_random();
		int n;
		vertex_item_t it;
		while (items_sent < 1100) begin
			if ($urandom_range(0, 29) == 0) begin
				drain();
				no_idle = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 3))
					0: set_extents(31'd0, 31'($urandom), 31'($urandom), 31'h7fffffff);
					1: set_extents(31'($urandom), 31'($urandom), 31'($urandom),
						31'($urandom));
					default: set_extents(31'($urandom_range(0, 90)),
						31'($urandom_range(0, 90)), 31'($urandom_range(0, 90)),
						31'($urandom_range(0, 90)));
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				it = rand_item(2'($urandom_range(0, 3)));
				if (it.cmd != pecc_pkg::CMD_CHECK) it.first = 1'b1;
				send_item(it);
				continue;
			end
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				put_vertex(pecc_pkg::CMD_LOAD_A, i == 0, rand_coord(), rand_coord());
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				put_vertex(pecc_pkg::CMD_LOAD_B, i == 0, rand_coord(), rand_coord());
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) send_item(rand_item(pecc_pkg::CMD_CHECK));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pecc_pkg::REG_EXT_A_X;
		cfg_data = '0;
		in_valid = 1'b0;
		command = pecc_pkg::CMD_LOAD_A;
		point_x = '0;
		point_y = '0;
		first_point = 1'b0;
		offset_a_x = '0;
		offset_a_y = '0;
		offset_b_x = '0;
		offset_b_y = '0;
		n_verts_a = 0;
		n_verts_b = 0;
		lost_vertex = 1'b0;
		ext_a_x = '0;
		ext_a_y = '0;
		ext_b_x = '0;
		ext_b_y = '0;
		mismatches = 0;
		items_sent = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_random();
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
